// ===== sv/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue
// Opcodes, status codes and the command broadcast to the row of cells.
// ----------------------------------------------------------------------------
package dq_pkg;

  // opcodes carried by an input transaction
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_LIST       = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // command broadcast to every cell in the row
  typedef enum logic [2:0] {
    CMD_HOLD       = 3'd0,
    CMD_SHIFT_IN   = 3'd1,  // take left neighbor, cell zero takes the pushed value
    CMD_LOAD_TAIL  = 3'd2,  // the cell just past the tail takes the pushed value
    CMD_SHIFT_OUT  = 3'd3,  // take right neighbor
    CMD_ROTATE     = 3'd4   // rotate occupied cells toward the front by one
  } cell_cmd_t;

endpackage

// ===== sv/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell: one slot of the queue
// Holds one stored value and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module dq_cell
  import dq_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_W     = 6,
  parameter int CELL_INDEX  = 0
) (
  input  logic                   clk,
  input  cell_cmd_t              cmd,
  input  logic [COUNT_W-1:0]     count,
  input  logic [COUNT_W-1:0]     tail,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic [VALUE_WIDTH-1:0] right_value,
  input  logic [VALUE_WIDTH-1:0] head_value,
  input  logic [VALUE_WIDTH-1:0] push_value,
  output logic [VALUE_WIDTH-1:0] value
);

  localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(CELL_INDEX);

  logic [VALUE_WIDTH-1:0] value_next;

  // select the new content of this slot
  always_comb begin
    value_next = value;
    unique case (cmd)
      CMD_HOLD:      value_next = value;
      CMD_SHIFT_IN:  value_next = left_value;
      CMD_LOAD_TAIL: if (count == MY_INDEX) value_next = push_value;
      CMD_SHIFT_OUT: value_next = right_value;
      CMD_ROTATE: begin
        if (tail == MY_INDEX) value_next = head_value;
        else                  value_next = right_value;
      end
      default:       value_next = value;
    endcase
  end

  // slot storage, no reset
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== sv/double_ended_queue.sv =====
// A push or pop result is registered and appears in the cycle after its transaction is accepted.
// Throughput: push and pop take one transaction per cycle while the output can load; list holds
// off input until every stored value is sent, one per cycle while the output can load, as the row of cells rotates.
// Reset (synchronous, rst high) empties the queue; slot contents stay undefined
// and are never read before written.
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque built as a row of shifting cells
// Outside a list run, cell zero holds the front and the back sits at cell count-1.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_value,
  output logic [1:0]         status,
  output logic               last_of_run
);

  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

  logic [VALUE_WIDTH-1:0] cells [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] push_value;
  logic signed [63:0]     in_ext;

  logic [COUNT_W-1:0] count, count_next;
  logic [COUNT_W-1:0] tail;
  logic               listing, listing_next;
  logic [COUNT_W-1:0] list_idx, list_idx_next;
  logic               load_ok, accept;
  cell_cmd_t          cmd;

  logic                   out_load;
  logic [VALUE_WIDTH-1:0] res_raw;
  logic [1:0]             res_status;
  logic                   res_last;
  logic signed [63:0]     res_ext;

  // keep low bits of the pushed value
  assign in_ext     = 64'(item_value);
  assign push_value = in_ext[VALUE_WIDTH-1:0];
  assign tail       = count - COUNT_W'(1);

  assign load_ok  = !out_valid || out_ready;
  assign in_ready = !listing && load_ok;
  assign accept   = in_valid && in_ready;

  // row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = push_value;
    end else begin : g_mid
      assign left_v = cells[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_v = cells[i];
    end else begin : g_inner
      assign right_v = cells[i+1];
    end
    dq_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_W     (COUNT_W),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .tail        (tail),
      .left_value  (left_v),
      .right_value (right_v),
      .head_value  (cells[0]),
      .push_value  (push_value),
      .value       (cells[i])
    );
  end

  // transaction decode and listing sequencer
  always_comb begin
    cmd           = CMD_HOLD;
    count_next    = count;
    listing_next  = listing;
    list_idx_next = list_idx;
    out_load      = 1'b0;
    res_raw       = '0;
    res_status    = ST_OK;
    res_last      = 1'b1;
    if (listing) begin
      if (load_ok) begin
        out_load      = 1'b1;
        res_raw       = cells[0];
        res_last      = (list_idx == tail);
        cmd           = CMD_ROTATE;
        list_idx_next = list_idx + COUNT_W'(1);
        if (list_idx == tail) listing_next = 1'b0;
      end
    end else if (accept) begin
      unique case (opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          out_load = 1'b1;
          if (count == FULL_COUNT) begin
            res_status = ST_FULL;
          end else begin
            res_raw    = push_value;
            count_next = count + COUNT_W'(1);
            cmd        = (opcode == OP_PUSH_FRONT) ? CMD_SHIFT_IN : CMD_LOAD_TAIL;
          end
        end
        OP_POP_FRONT: begin
          out_load = 1'b1;
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_raw    = cells[0];
            count_next = tail;
            cmd        = CMD_SHIFT_OUT;
          end
        end
        OP_POP_BACK: begin
          out_load = 1'b1;
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_raw    = cells[tail[IDX_W-1:0]];
            count_next = tail;
          end
        end
        OP_LIST: begin
          if (count == '0) begin
            out_load   = 1'b1;
            res_status = ST_EMPTY;
          end else begin
            listing_next  = 1'b1;
            list_idx_next = '0;
          end
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end
  end

  assign res_ext = 64'(signed'(res_raw));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      listing   <= 1'b0;
      list_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      count    <= count_next;
      listing  <= listing_next;
      list_idx <= list_idx_next;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value <= res_ext[31:0];
      status       <= res_status;
      last_of_run  <= res_last;
    end
  end

endmodule
